FILE: sv/utf8wte_pkg.sv
// Shared types, constants and the code point weight function of the token estimator.
`default_nettype none

package utf8wte_pkg;

    // Weights in twentieths of a token.
    localparam logic [5:0] W_TEXT    = 6'd5;
    localparam logic [5:0] W_DIGIT   = 6'd6;
    localparam logic [5:0] W_CONTROL = 6'd12;
    localparam logic [5:0] W_TWO     = 6'd10;
    localparam logic [5:0] W_THREE   = 6'd30;
    localparam logic [5:0] W_FOUR    = 6'd40;

    // Field widths of the stream payloads.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned EST_W    = 20;
    localparam int unsigned M_DATA_W = 24;
    localparam int unsigned OVH_W    = 8;

    // Estimate limit, and the rounded sum at or above which the quotient reaches 2^20.
    localparam logic [EST_W-1:0] EST_MAX   = 20'hFFFFF;
    localparam logic [24:0]      SUM_LIMIT = 25'd20971520;

    // Reciprocal of five, scaled by 2^26 and rounded up.
    localparam logic [23:0]      RECIP5    = 24'd13421773;
    localparam int unsigned      RECIP_SH  = 26;

    // Reset value of the overhead register.
    localparam logic [OVH_W-1:0] OVH_RESET = 8'd4;

    // Control bits travelling with a finished text total.
    typedef struct packed {
        logic valid;
        logic stopped;
    } t_done_info;

    // Weight of one decoded code point.
    function automatic logic [5:0] cp_weight(input logic [CP_W-1:0] cp);
        logic [6:0] a;
        logic [5:0] w;
        a = cp[6:0];
        if (cp < 21'h80) begin
            if ((a >= 7'h41 && a <= 7'h5A) || (a >= 7'h61 && a <= 7'h7A)) begin
                w = W_TEXT;
            end else if (a >= 7'h30 && a <= 7'h39) begin
                w = W_DIGIT;
            end else if (a == 7'h20 || (a >= 7'h09 && a <= 7'h0D)) begin
                w = W_TEXT;
            end else if ((a >= 7'h21 && a <= 7'h2F) || (a >= 7'h3A && a <= 7'h40) ||
                         (a >= 7'h5B && a <= 7'h60) || (a >= 7'h7B && a <= 7'h7E)) begin
                w = W_TEXT;
            end else begin
                w = W_CONTROL;
            end
        end else if (cp < 21'h800) begin
            w = W_TWO;
        end else if (cp < 21'h10000) begin
            w = W_THREE;
        end else begin
            w = W_FOUR;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: sv/utf8_weighted_token_estimator.sv
// Top level of the UTF-8 weighted token estimator.
//
//  Channel   Direction  Payload
//  s_*       in         tdata[7:0] data_byte, tuser byte_present, tlast end_of_text
//  m_*       out        tdata[19:0] token_estimate (bits 23:20 zero), tuser stopped_early
//  i_cfg_*   in         overhead_tokens, 8 bits, written when i_cfg_we is high
//
//  One input item is taken per cycle while s_tready is high; each byte is decoded
//  and weighted in the cycle it is accepted.
//  A result item reaches m_* from its end-of-text item through the capture, rounding,
//  reciprocal multiply and overhead registers in that order.
//  s_tready falls only when all result stages are full and m_tready is low.
//  Reset is synchronous; it clears the text state and sets the overhead to 4.
`default_nettype none

module utf8_weighted_token_estimator #(
    parameter int unsigned ACC_WIDTH = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [19:0] token_estimate, [23:20] zero
    output logic             m_tuser,   // [0] stopped_early
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);
    import utf8wte_pkg::*;

    logic [OVH_W-1:0]     r_overhead;
    logic                 accept;
    t_done_info           done;
    logic [ACC_WIDTH-1:0] total;
    logic [EST_W-1:0]     estimate;

    assign accept = s_tvalid && s_tready;

    // Overhead register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overhead <= OVH_RESET;
        end else if (i_cfg_we) begin
            r_overhead <= i_cfg_wdata;
        end
    end

    utf8wte_decode #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (s_tdata),
        .i_present (s_tuser),
        .i_last    (s_tlast),
        .o_done    (done),
        .o_total   (total)
    );

    utf8wte_scale #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_done     (done),
        .i_total    (total),
        .i_overhead (r_overhead),
        .o_ready    (s_tready),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_estimate (estimate),
        .o_stopped  (m_tuser)
    );

    assign m_tdata = {(M_DATA_W-EST_W)'(0), estimate};

endmodule

`default_nettype wire

FILE: sv/utf8wte_decode.sv
// UTF-8 decoder state and saturating weight accumulator, one byte per cycle while i_accept is high.
`default_nettype none

module utf8wte_decode #(
    parameter int unsigned ACC_WIDTH = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [utf8wte_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                          i_present,
    input  wire logic                          i_last,
    output utf8wte_pkg::t_done_info            o_done,
    output logic [ACC_WIDTH-1:0]               o_total
);
    import utf8wte_pkg::*;

    logic [1:0]           r_pending, n_pending;
    logic [CP_W-1:0]      r_partial, n_partial;
    logic [ACC_WIDTH-1:0] r_total,   n_total;
    logic                 r_halted,  n_halted;

    logic                 add_en;
    logic [CP_W-1:0]      add_cp;
    logic [CP_W-1:0]      cont_cp;
    logic [5:0]           weight;
    logic [ACC_WIDTH:0]   acc_sum;

    assign cont_cp = {r_partial[CP_W-7:0], i_byte[5:0]};
    assign weight  = cp_weight(add_cp);
    assign acc_sum = {1'b0, r_total} + (ACC_WIDTH+1)'(weight);

    // Byte decode, weight add and end-of-text hand-over.
    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        n_halted  = r_halted;
        add_en    = 1'b0;
        add_cp    = '0;
        if (i_accept && i_present && !r_halted) begin
            if (r_pending != 2'd0) begin
                if (i_byte[7:6] != 2'b10) begin
                    // Bad continuation byte: drop the unfinished code point.
                    n_halted  = 1'b1;
                    n_pending = 2'd0;
                    n_partial = '0;
                end else if (r_pending == 2'd1) begin
                    add_en    = 1'b1;
                    add_cp    = cont_cp;
                    n_pending = 2'd0;
                    n_partial = '0;
                end else begin
                    n_pending = r_pending - 2'd1;
                    n_partial = cont_cp;
                end
            end else begin
                priority if (i_byte[7] == 1'b0) begin
                    add_en = 1'b1;
                    add_cp = CP_W'(i_byte);
                end else if (i_byte[7:5] == 3'b110) begin
                    n_pending = 2'd1;
                    n_partial = CP_W'(i_byte[4:0]);
                end else if (i_byte[7:4] == 4'b1110) begin
                    n_pending = 2'd2;
                    n_partial = CP_W'(i_byte[3:0]);
                end else if (i_byte[7:3] == 5'b11110) begin
                    n_pending = 2'd3;
                    n_partial = CP_W'(i_byte[2:0]);
                end else begin
                    n_halted = 1'b1;
                end
            end
        end

        if (!add_en) begin
            n_total = r_total;
        end else if (acc_sum[ACC_WIDTH]) begin
            n_total = '1;
        end else begin
            n_total = acc_sum[ACC_WIDTH-1:0];
        end

        // The last item of a text passes its total on and clears the text state.
        o_done.valid   = i_accept && i_last;
        o_done.stopped = n_halted || (n_pending != 2'd0);
        o_total        = n_total;
        if (i_accept && i_last) begin
            n_pending = 2'd0;
            n_partial = '0;
            n_total   = '0;
            n_halted  = 1'b0;
        end
    end

    // Text state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
            r_total   <= '0;
            r_halted  <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_total   <= n_total;
            r_halted  <= n_halted;
        end
    end

endmodule

`default_nettype wire

FILE: sv/utf8wte_scale.sv
// Result pipeline: round, divide by twenty, add the overhead and hold the result item.
`default_nettype none

module utf8wte_scale #(
    parameter int unsigned ACC_WIDTH = 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire utf8wte_pkg::t_done_info         i_done,
    input  wire logic [ACC_WIDTH-1:0]            i_total,
    input  wire logic [utf8wte_pkg::OVH_W-1:0]   i_overhead,
    output logic                                 o_ready,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [utf8wte_pkg::EST_W-1:0]        o_estimate,
    output logic                                 o_stopped
);
    import utf8wte_pkg::*;

    // Rounded sum is kept at least wide enough to compare against the limit.
    localparam int unsigned EXT_W = (ACC_WIDTH + 1 > 25) ? ACC_WIDTH + 1 : 25;
    localparam int unsigned X_W   = 23;
    localparam int unsigned P_W   = X_W + 24;

    // Stage 1: captured total.
    logic                 r_s1_valid, r_s1_stopped;
    logic [ACC_WIDTH-1:0] r_s1_total;
    // Stage 2: rounded sum divided by four, and the overflow flag.
    logic                 r_s2_valid, r_s2_stopped, r_s2_sat;
    logic [X_W-1:0]       r_s2_x;
    // Stage 3: quotient by five.
    logic                 r_s3_valid, r_s3_stopped, r_s3_sat;
    logic [EST_W-1:0]     r_s3_q;
    // Output register.
    logic                 r_o_valid, r_o_stopped;
    logic [EST_W-1:0]     r_o_est;

    logic                 out_free, s3_free, s2_free, s1_free;
    logic [EXT_W-1:0]     round_sum;
    logic [P_W-1:0]       product;
    logic [EST_W:0]       est_sum;
    logic [EST_W-1:0]     n_o_est;

    assign out_free = !r_o_valid || i_ready;
    assign s3_free  = !r_s3_valid || out_free;
    assign s2_free  = !r_s2_valid || s3_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign o_ready  = s1_free;

    assign round_sum = EXT_W'(r_s1_total) + EXT_W'(10);
    assign product   = P_W'(r_s2_x) * P_W'(RECIP5);
    assign est_sum   = {1'b0, r_s3_q} + (EST_W+1)'(i_overhead);
    assign n_o_est   = (r_s3_sat || est_sum[EST_W]) ? EST_MAX : est_sum[EST_W-1:0];

    // Valid flags of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_done.valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_free) begin
                r_s3_valid <= r_s2_valid;
            end
            if (out_free) begin
                r_o_valid <= r_s3_valid;
            end
        end
    end

    // Payload of the stages.
    always_ff @(posedge i_clk) begin
        if (s1_free && i_done.valid) begin
            r_s1_total   <= i_total;
            r_s1_stopped <= i_done.stopped;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_sat     <= round_sum >= EXT_W'(SUM_LIMIT);
            r_s2_x       <= round_sum[X_W+1:2];
            r_s2_stopped <= r_s1_stopped;
        end
        if (s3_free && r_s2_valid) begin
            r_s3_q       <= product[RECIP_SH+EST_W-1:RECIP_SH];
            r_s3_sat     <= r_s2_sat;
            r_s3_stopped <= r_s2_stopped;
        end
        if (out_free && r_s3_valid) begin
            r_o_est      <= n_o_est;
            r_o_stopped  <= r_s3_stopped;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_estimate = r_o_est;
    assign o_stopped  = r_o_stopped;

endmodule

`default_nettype wire

FILE: sv/utf8wte_checker.sv
// Port-level checks of the token estimator and their binding to the top level.
`default_nettype none

module utf8wte_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser
);

    // A stalled result item holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // The estimate never exceeds twenty bits.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[23:20] == 4'd0)
        else $error("padding bits of the result are set");

    // Input back-pressure only arises from a stalled output.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the output is free");

    // Reset empties the result side.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result item present after reset");

endmodule

bind utf8_weighted_token_estimator utf8wte_checker u_checker (.*);

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the UTF-8 weighted token estimator stream block.
`timescale 1ns / 100ps

module testbench;

    // Accumulator width of the block under test.
    localparam int unsigned ACC_W     = 16;
    localparam logic [ACC_W-1:0] ACC_TOP = {ACC_W{1'b1}};
    localparam logic [19:0] EST_TOP   = 20'hFFFFF;
    localparam logic [7:0]  OVH_RESET = 8'd4;

    // Weights in twentieths of a token.
    localparam logic [5:0] WT_TEXT    = 6'd5;
    localparam logic [5:0] WT_DIGIT   = 6'd6;
    localparam logic [5:0] WT_CONTROL = 6'd12;
    localparam logic [5:0] WT_TWO     = 6'd10;
    localparam logic [5:0] WT_THREE   = 6'd30;
    localparam logic [5:0] WT_FOUR    = 6'd40;

    // Cycles to let pass after the last result before touching the register, and length of the receiver hold-off.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_text_item;

    typedef struct packed {
        logic [19:0] estimate;
        logic        stopped;
    } t_estimate;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;    // [7:0] data_byte
    logic        s_tuser     = 1'b0;    // [0] byte_present
    logic        s_tlast     = 1'b0;    // end_of_text
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;               // [19:0] token_estimate, [23:20] zero
    logic        m_tuser;               // [0] stopped_early
    logic        i_cfg_we    = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;

    t_text_item  byte_q[$];
    t_estimate   estimate_q[$];
    t_text_item  offer;
    t_estimate   seen;
    int          queued_items   = 0;
    int          fail_count     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          pressure_armed = 1'b0;
    bit          pressure_taken = 1'b0;
    int          hold_left      = 0;

    // Predictor state.
    logic [1:0]       conts_due;
    logic [20:0]      partial_cp;
    logic [ACC_W-1:0] weight_sum;
    logic             halted;
    logic [7:0]       overhead;

    utf8_weighted_token_estimator #(
        .ACC_WIDTH (ACC_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Weight of one decoded code point.
    function automatic logic [5:0] codepoint_weight(input logic [20:0] cp);
        logic [6:0] c;
        c = cp[6:0];
        if (cp >= 21'h10000) return WT_FOUR;
        if (cp >= 21'h800) return WT_THREE;
        if (cp >= 21'h80) return WT_TWO;
        if ((c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A)) return WT_TEXT;
        if (c >= 7'h30 && c <= 7'h39) return WT_DIGIT;
        if (c == 7'h20 || (c >= 7'h09 && c <= 7'h0D)) return WT_TEXT;
        if ((c >= 7'h21 && c <= 7'h2F) || (c >= 7'h3A && c <= 7'h40) ||
            (c >= 7'h5B && c <= 7'h60) || (c >= 7'h7B && c <= 7'h7E)) return WT_TEXT;
        return WT_CONTROL;
    endfunction

    // Saturating add of one code point weight to the running sum.
    task automatic add_weight(input logic [20:0] cp);
        logic [ACC_W:0] sum;
        sum = {1'b0, weight_sum} + (ACC_W+1)'(codepoint_weight(cp));
        weight_sum = sum[ACC_W] ? ACC_TOP : sum[ACC_W-1:0];
    endtask

    // Decode one accepted item and queue the estimate when it closes a text.
    task automatic track_item(input t_text_item it);
        t_estimate   res;
        logic [31:0] est;
        if (it.present && !halted) begin
            if (conts_due != 2'd0) begin
                if (it.data[7:6] != 2'b10) begin
                    // Broken continuation: drop the unfinished code point and stop.
                    halted     = 1'b1;
                    conts_due  = 2'd0;
                    partial_cp = 21'd0;
                end else begin
                    partial_cp = {partial_cp[14:0], it.data[5:0]};
                    conts_due  = conts_due - 2'd1;
                    if (conts_due == 2'd0) begin
                        add_weight(partial_cp);
                        partial_cp = 21'd0;
                    end
                end
            end else if (!it.data[7]) begin
                add_weight({13'd0, it.data});
            end else if (it.data[7:5] == 3'b110) begin
                conts_due  = 2'd1;
                partial_cp = {16'd0, it.data[4:0]};
            end else if (it.data[7:4] == 4'b1110) begin
                conts_due  = 2'd2;
                partial_cp = {17'd0, it.data[3:0]};
            end else if (it.data[7:3] == 5'b11110) begin
                conts_due  = 2'd3;
                partial_cp = {18'd0, it.data[2:0]};
            end else begin
                halted = 1'b1;
            end
        end
        if (it.last) begin
            est = (32'(weight_sum) + 32'd10) / 32'd20 + 32'(overhead);
            res.estimate = (est > 32'(EST_TOP)) ? EST_TOP : est[19:0];
            res.stopped  = halted || (conts_due != 2'd0);
            estimate_q.push_back(res);
            conts_due  = 2'd0;
            partial_cp = 21'd0;
            weight_sum = '0;
            halted     = 1'b0;
        end
    endtask

    // Predictor: follows every accepted item and every register write.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            conts_due  = 2'd0;
            partial_cp = 21'd0;
            weight_sum = '0;
            halted     = 1'b0;
            overhead   = OVH_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                track_item('{data: s_tdata, present: s_tuser, last: s_tlast});
            end
            if (i_cfg_we) begin
                overhead = i_cfg_wdata;
            end
        end
    end

    // Driver: offers queued items, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                offer = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= offer.data;
                s_tuser  <= offer.present;
                s_tlast  <= offer.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, armed once, so that the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (pressure_armed && !pressure_taken) begin
            hold_left      <= HOLD_CYCLES;
            pressure_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each result item against the oldest expected estimate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (estimate_q.size() == 0) begin
                    $error("unexpected result item: token_estimate %0d stopped_early %0d",
                           m_tdata[19:0], m_tuser);
                    fail_count++;
                end else begin
                    seen = estimate_q.pop_front();
                    if (m_tdata[19:0] !== seen.estimate) begin
                        $error("token_estimate: expected %0d, actual %0d",
                               seen.estimate, m_tdata[19:0]);
                        fail_count++;
                    end
                    if (m_tuser !== seen.stopped) begin
                        $error("stopped_early: expected %0d, actual %0d",
                               seen.stopped, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[23:20] !== 4'd0) begin
                        $error("tdata padding: expected 0, actual %0h", m_tdata[23:20]);
                        fail_count++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_item(input logic [7:0] data, input logic present, input logic last);
        byte_q.push_back('{data: data, present: present, last: last});
        queued_items++;
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // One random text: mostly well-formed code points, with noise, breaks and cut tails.
    task automatic gen_text();
        logic [7:0] seq[$];
        int         n_cp;
        int         kind;
        int         pos;
        bit         end_alone;
        n_cp = $urandom_range(0, 10);
        for (int i = 0; i < n_cp; i++) begin
            kind = $urandom_range(0, 19);
            if (kind < 10) begin
                seq.push_back(8'($urandom_range(0, 127)));
            end else if (kind < 13) begin
                seq.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                seq.push_back(cont_byte());
            end else if (kind < 16) begin
                seq.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                seq.push_back(cont_byte());
                seq.push_back(cont_byte());
            end else if (kind < 19) begin
                seq.push_back(8'hF0 | 8'($urandom_range(0, 7)));
                seq.push_back(cont_byte());
                seq.push_back(cont_byte());
                seq.push_back(cont_byte());
            end else begin
                seq.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (seq.size() != 0 && $urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, seq.size() - 1);
            seq[pos] = 8'($urandom_range(0, 255));
        end
        if (seq.size() != 0 && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                if (seq.size() != 0) void'(seq.pop_back());
            end
        end
        end_alone = (seq.size() == 0) || ($urandom_range(0, 3) == 0);
        foreach (seq[i]) begin
            if ($urandom_range(0, 11) == 0) push_item(8'($urandom), 1'b0, 1'b0);
            push_item(seq[i], 1'b1, !end_alone && (i == seq.size() - 1));
        end
        if (end_alone) push_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic run_random(input int n);
        int target;
        target = queued_items + n;
        while (queued_items < target) gen_text();
    endtask

    // Wait until every item is taken and every estimate has arrived, then let the pipe settle.
    task automatic settle();
        @(negedge i_clk);
        while (byte_q.size() != 0 || s_tvalid || estimate_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_overhead(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stimulus sequence and final verdict.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texts at the reset overhead, no idling.
        // Empty text: an item with no byte that closes it.
        push_item(8'hA5, 1'b0, 1'b1);
        // Letters, digits, space, punctuation, controls, a no-byte item, then
        // two-, three- and four-byte forms including an overlong one and the top value.
        push_item(8'h41, 1'b1, 1'b0);
        push_item(8'h30, 1'b1, 1'b0);
        push_item(8'h20, 1'b1, 1'b0);
        push_item(8'h7E, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h7F, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'hDF, 1'b1, 1'b0);
        push_item(8'hBF, 1'b1, 1'b0);
        push_item(8'hE0, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'hF7, 1'b1, 1'b0);
        push_item(8'hBF, 1'b1, 1'b0);
        push_item(8'hBF, 1'b1, 1'b0);
        push_item(8'hBF, 1'b1, 1'b1);
        // Bad continuation byte: it is not taken as a new lead byte.
        push_item(8'hC3, 1'b1, 1'b0);
        push_item(8'h41, 1'b1, 1'b0);
        push_item(8'h42, 1'b1, 1'b1);
        // Sequence cut off at end of text.
        push_item(8'hE2, 1'b1, 1'b0);
        push_item(8'h82, 1'b1, 1'b1);
        // Bad lead bytes: a stray continuation, then one of the 11111xxx form.
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h61, 1'b1, 1'b1);
        push_item(8'hF8, 1'b1, 1'b1);
        settle();

        // Largest overhead, sender mostly idle.
        write_overhead(8'd255);
        send_idle_pct  = 76;
        recv_stall_pct = 0;
        run_random(300);
        settle();

        // No overhead, receiver mostly stalling.
        write_overhead(8'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        run_random(300);
        settle();

        // Random overhead, both sides idling.
        write_overhead(8'($urandom_range(1, 254)));
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        run_random(300);
        settle();

        // No idling, with one long receiver hold-off while the sender keeps offering.
        write_overhead(8'd17);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_armed = 1'b1;
        run_random(220);
        settle();

        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Watchdog for a run that hangs.
    initial begin
        #10000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
